/* design/hbt_pkg.sv */
package hbt_pkg;

    localparam int MAX_CH     = 16;
    localparam int CH_W       = 4;
    localparam int THR_W      = 16;
    localparam int TICK_W     = 32;
    localparam int CFG_W      = 64;
    localparam int CFG_IDX_W  = 8;
    localparam int NUM_THR_REGS = 4;
    localparam int THR_PER_REG  = CFG_W / THR_W;

    // counter wraps to zero on reaching this value
    localparam logic [TICK_W-1:0] TICK_WRAP = 32'd4294967200;

    typedef enum logic {
        OP_TICK      = 1'b0,
        OP_HEARTBEAT = 1'b1
    } t_op;

    typedef logic [CFG_W-1:0] t_thr_regs [NUM_THR_REGS];

    localparam t_thr_regs THR_RESET = '{
        64'h000A_000A_000A_0005,
        64'h000A_000A_000A_000A,
        64'h0000_0000_0000_000A,
        64'h0000_0000_0000_0000
    };

    typedef logic [THR_W-1:0] t_thr_vec [MAX_CH];

    typedef struct packed {
        t_op             op;
        logic [CH_W-1:0] ch;
    } t_item;

    typedef struct packed {
        logic            any_timeout;
        logic [CH_W-1:0] timeout_channel;
    } t_stat;

endpackage

/* design/hbt_in_stage.sv */
module hbt_in_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  hbt_pkg::t_item i_item,
    input  logic          i_advance,
    output logic          o_valid,
    output hbt_pkg::t_item o_item
);
    import hbt_pkg::*;

    logic  r_valid;
    t_item r_item;

    // slot frees up whenever the core consumes it this cycle
    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

/* design/hbt_core.sv */
module hbt_core #(
    parameter int NUM_CHANNELS = 9
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  hbt_pkg::t_item    i_item,
    input  hbt_pkg::t_thr_vec i_thr,
    output hbt_pkg::t_stat    o_stat
);
    import hbt_pkg::*;

    logic [TICK_W-1:0] r_tick;
    logic [TICK_W-1:0] n_tick;
    logic [TICK_W-1:0] r_last [NUM_CHANNELS];
    logic [TICK_W-1:0] w_diff [NUM_CHANNELS];
    t_stat             r_stat;
    t_stat             n_stat;
    logic [TICK_W-1:0] w_tick_inc;

    assign w_tick_inc = r_tick + 32'd1;

    always_comb begin
        n_tick = r_tick;
        if (i_item.op == OP_TICK) begin
            n_tick = (w_tick_inc >= TICK_WRAP) ? '0 : w_tick_inc;
        end
    end

    for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_diff
        assign w_diff[g] = n_tick - r_last[g];
    end

    // highest timed-out channel wins
    always_comb begin
        n_stat = r_stat;
        if (i_item.op == OP_TICK) begin
            n_stat = '0;
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                if (w_diff[c] >= {{(TICK_W-THR_W){1'b0}}, i_thr[c]}) begin
                    n_stat.any_timeout     = 1'b1;
                    n_stat.timeout_channel = CH_W'(c);
                end
            end
        end
    end

    assign o_stat = n_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick <= '0;
            r_stat <= '0;
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                r_last[c] <= '0;
            end
        end else if (i_en) begin
            r_tick <= n_tick;
            r_stat <= n_stat;
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                if (i_item.op == OP_HEARTBEAT && i_item.ch == CH_W'(c)) begin
                    r_last[c] <= r_tick;
                end
            end
        end
    end

endmodule

/* design/multi_channel_heartbeat_timeout.sv */
// Heartbeat dropout monitor for up to 16 channels. Each input beat is either a
// tick (tuser = 0) or a heartbeat from the channel in tdata (tuser = 1). A tick
// advances a 32-bit counter (wrapping at 4294967200) and flags the highest
// channel whose ticks since its last heartbeat reach its 16-bit threshold; a
// zero threshold always flags. Every input beat returns one output beat with
// the latched status. One beat per cycle is sustained while the output is ready;
// an item passes an input register and one compare/priority-encode stage into
// the output register, which holds the output beat. Output backpressure stalls
// the input directly. Thresholds are set through the config port (index 0..3,
// four channels per 64-bit register, lowest channel in the low bits) and
// should only be written while idle.
module multi_channel_heartbeat_timeout #(
    parameter int NUM_CHANNELS = 9
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [3:0] channel, [7:4] zero
    input  logic        s_axis_tuser,   // [0] operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [3:0] timeout_channel, [7:4] zero
    output logic        m_axis_tuser,   // [0] any_timeout
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [hbt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [hbt_pkg::CFG_W-1:0]     i_cfg_data
);
    import hbt_pkg::*;

    t_thr_regs r_thr;
    t_thr_vec  w_thr;
    t_item     w_in_item;
    t_item     w_core_item;
    logic      w_core_valid;
    logic      w_advance;
    t_stat     w_stat;
    logic      r_out_valid;
    t_stat     r_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_valid) begin
            for (int r = 0; r < NUM_THR_REGS; r++) begin
                if (i_cfg_index == CFG_IDX_W'(r)) begin
                    r_thr[r] <= i_cfg_data;
                end
            end
        end
    end

    for (genvar g = 0; g < MAX_CH; g++) begin : g_thr
        assign w_thr[g] = r_thr[g / THR_PER_REG][(g % THR_PER_REG)*THR_W +: THR_W];
    end

    assign w_in_item.op = t_op'(s_axis_tuser);
    assign w_in_item.ch = s_axis_tdata[CH_W-1:0];

    // pipeline moves when the output slot is empty or being drained
    assign w_advance = !r_out_valid || m_axis_tready;

    hbt_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_item    (w_in_item),
        .i_advance (w_advance),
        .o_valid   (w_core_valid),
        .o_item    (w_core_item)
    );

    hbt_core #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_advance && w_core_valid),
        .i_item  (w_core_item),
        .i_thr   (w_thr),
        .o_stat  (w_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_core_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_core_valid) begin
            r_out <= w_stat;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.any_timeout;
    assign m_axis_tdata  = {{(8-CH_W){1'b0}}, r_out.timeout_channel};

endmodule

/* tb/multi_channel_heartbeat_timeout_tb.sv */
`timescale 1ns / 100ps

module multi_channel_heartbeat_timeout_tb;
    import hbt_pkg::*;

    localparam int NCH         = 9;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 175;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata  = '0;   // [3:0] channel, [7:4] zero
    logic                 s_axis_tuser  = 1'b0; // [0] operation
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [7:0]           m_axis_tdata;         // [3:0] timeout_channel, [7:4] zero
    logic                 m_axis_tuser;         // [0] any_timeout
    logic                 i_cfg_valid   = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [CFG_W-1:0]     i_cfg_data    = '0;

    // shadow of the monitor state
    logic [CFG_W-1:0]  thr_shadow [NUM_THR_REGS];
    logic [TICK_W-1:0] ticks_now;
    logic [TICK_W-1:0] seen_at [MAX_CH];
    logic              latched_flag;
    logic [CH_W-1:0]   latched_ch;

    t_stat status_due [$];
    int    errors      = 0;
    int    cycle_count = 0;
    bit    quiet       = 1'b0;

    multi_channel_heartbeat_timeout #(
        .NUM_CHANNELS(NCH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch: %s got %0d expected %0d", $time, what, got, want);
        errors++;
    endtask

    function automatic void reset_shadow();
        for (int r = 0; r < NUM_THR_REGS; r++) thr_shadow[r] = THR_RESET[r];
        ticks_now = '0;
        for (int c = 0; c < MAX_CH; c++) seen_at[c] = '0;
        latched_flag = 1'b0;
        latched_ch   = '0;
    endfunction

    function automatic t_stat advance_monitor(input t_op op, input logic [CH_W-1:0] ch);
        t_stat             st;
        logic [THR_W-1:0]  thr;
        logic [TICK_W-1:0] age;
        logic              hit;
        logic [CH_W-1:0]   hit_ch;
        if (op == OP_TICK) begin
            ticks_now = ticks_now + 32'd1;
            if (ticks_now >= TICK_WRAP) ticks_now = '0;
            hit    = 1'b0;
            hit_ch = '0;
            for (int c = 0; c < NCH; c++) begin
                thr = thr_shadow[c / THR_PER_REG][(c % THR_PER_REG) * THR_W +: THR_W];
                age = ticks_now - seen_at[c];
                if (age >= {16'b0, thr}) begin
                    hit    = 1'b1;
                    hit_ch = CH_W'(c);
                end
            end
            latched_flag = hit;
            latched_ch   = hit_ch;
        end else if (ch < NCH) begin
            seen_at[ch] = ticks_now;
        end
        st.any_timeout     = latched_flag;
        st.timeout_channel = latched_ch;
        return st;
    endfunction

    // one input beat; leaves tvalid high so back-to-back beats need no re-raise
    task automatic send_event(input t_op op, input logic [CH_W-1:0] ch);
        if (!quiet && $urandom_range(0, 99) < 4) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0000, ch};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        status_due.push_back(advance_monitor(op, ch));
    endtask

    task automatic write_thresholds(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        if (idx < NUM_THR_REGS) thr_shadow[idx[1:0]] = val;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (status_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_stat want;
        m_axis_tready <= quiet || ($urandom_range(0, 99) >= 7);
        if (i_rst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready) begin
            if (status_due.size() == 0) begin
                report_mismatch("unexpected status beat", int'(m_axis_tdata), -1);
            end else begin
                want = status_due.pop_front();
                if (m_axis_tuser !== want.any_timeout)
                    report_mismatch("any_timeout", int'(m_axis_tuser),
                                    int'(want.any_timeout));
                if (m_axis_tdata[3:0] !== want.timeout_channel)
                    report_mismatch("timeout_channel", int'(m_axis_tdata[3:0]),
                                    int'(want.timeout_channel));
            end
        end
    end

    // default thresholds: ch0 trips after 5 ticks, a heartbeat clears it
    task automatic test_reset_thresholds();
        send_event(OP_HEARTBEAT, 4'd15);
        send_event(OP_HEARTBEAT, 4'd3);
        repeat (6) send_event(OP_TICK, 4'd0);
        send_event(OP_HEARTBEAT, 4'd0);
        send_event(OP_TICK, 4'd15);
    endtask

    // zero threshold flags every channel; highest active one wins
    task automatic test_zero_threshold();
        wait_idle();
        for (int r = 0; r < NUM_THR_REGS; r++) write_thresholds(CFG_IDX_W'(r), '0);
        send_event(OP_TICK, 4'd0);
        send_event(OP_HEARTBEAT, 4'd8);
        send_event(OP_TICK, 4'd7);
    endtask

    task automatic test_max_threshold();
        wait_idle();
        for (int r = 0; r < NUM_THR_REGS; r++) write_thresholds(CFG_IDX_W'(r), '1);
        send_event(OP_TICK, 4'd0);
        send_event(OP_TICK, 4'd10);
    endtask

    task automatic test_ignored_channels();
        wait_idle();
        write_thresholds(8'd2, 64'hFFFF_FFFF_FFFF_0002);
        send_event(OP_HEARTBEAT, 4'd8);
        send_event(OP_TICK, 4'd0);
        send_event(OP_TICK, 4'd0);
        send_event(OP_HEARTBEAT, 4'd9);
        send_event(OP_HEARTBEAT, 4'd12);
        send_event(OP_HEARTBEAT, 4'd15);
        send_event(OP_TICK, 4'd0);
    endtask

    // writes past the last register must leave thresholds alone
    task automatic test_bad_index();
        wait_idle();
        write_thresholds(8'd2, '1);
        write_thresholds(8'd4, '0);
        write_thresholds(8'd255, '0);
        write_thresholds(CFG_IDX_W'($urandom_range(5, 254)), '0);
        send_event(OP_HEARTBEAT, 4'd8);
        send_event(OP_TICK, 4'd0);
    endtask

    function automatic logic [THR_W-1:0] pick_threshold();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return '0;
        if (r < 20) return THR_W'($urandom);
        return THR_W'($urandom_range(1, 25));
    endfunction

    task automatic test_random_traffic();
        logic [CFG_W-1:0] val;
        int               tick_pct;
        int               n;
        int               r;
        t_op              op;
        logic [CH_W-1:0]  ch;
        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            for (int reg_i = 0; reg_i < NUM_THR_REGS; reg_i++) begin
                if (p == 0) val = '0;
                else if (p == 1) val = '1;
                else if (p == PHASES - 1) val = {$urandom, $urandom};
                else val = {pick_threshold(), pick_threshold(),
                            pick_threshold(), pick_threshold()};
                write_thresholds(CFG_IDX_W'(reg_i), val);
            end
            quiet    = (p == 4);
            tick_pct = $urandom_range(20, 80);
            n        = 0;
            while (n < PHASE_ITEMS) begin
                r = $urandom_range(0, 99);
                if (r < tick_pct) begin
                    op = OP_TICK;
                    ch = CH_W'($urandom_range(0, 15));
                end else if (r < 96) begin
                    op = OP_HEARTBEAT;
                    ch = CH_W'($urandom_range(0, NCH - 1));
                end else begin
                    op = OP_HEARTBEAT;
                    ch = CH_W'($urandom_range(NCH, 15));
                end
                send_event(op, ch);
                if (op == OP_TICK || ch < NCH) n++;
            end
            quiet = 1'b0;
        end
    endtask

    initial begin
        reset_shadow();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_thresholds();
        test_zero_threshold();
        test_max_threshold();
        test_ignored_channels();
        test_bad_index();
        test_random_traffic();
        wait_idle();
        if (status_due.size() != 0)
            report_mismatch("status beats never delivered", 0, status_due.size());
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* multi_channel_heartbeat_timeout.f */
design/hbt_pkg.sv
design/hbt_in_stage.sv
design/hbt_core.sv
design/multi_channel_heartbeat_timeout.sv
tb/multi_channel_heartbeat_timeout_tb.sv
